// File: hw/rtl/ppmsfd_pkg.sv
package ppmsfd_pkg;

	// Number of interval slots kept by the decoder.
	localparam int unsigned NUM_SLOTS   = 12;
	localparam int unsigned SLOT_IDX_W  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

	localparam logic [15:0] SYNC_GAP_MIN_RST = 16'd4000;
	localparam logic [15:0] SYNC_GAP_MAX_RST = 16'd21000;
	localparam logic [15:0] PULSE_MIN_RST    = 16'd900;
	localparam logic [15:0] PULSE_MAX_RST    = 16'd2200;
	localparam logic [3:0]  FINAL_SLOT_RST   = 4'd8;
	localparam logic [15:0] SLOT_RST         = 16'd1500;

	localparam logic [3:0]  PTR_MAX   = 4'd15;
	localparam logic [3:0]  COUNT_MAX = 4'd15;

	typedef enum logic [2:0] {
		REG_SYNC_GAP_MIN = 3'd0,
		REG_SYNC_GAP_MAX = 3'd1,
		REG_PULSE_MIN    = 3'd2,
		REG_PULSE_MAX    = 3'd3,
		REG_FINAL_SLOT   = 3'd4
	} cfg_reg_t;

	typedef enum logic {
		ACT_EDGE = 1'b0,
		ACT_READ = 1'b1
	} action_t;

endpackage

// File: hw/rtl/ppm_sum_frame_decoder.sv
// PPM sum-stream frame decoder.
// Input beats on the s_ channel carry either a rising-edge timestamp
// (s_tuser low) or a slot read request (s_tuser high). Each accepted beat
// yields exactly one result beat on the m_ channel with the stored slot
// value (zero for edge beats), the in-window pulse count, the in-frame flag
// and the slot index the next interval goes to.
// An edge beat measures the wrapping interval since the previous edge; a
// gap inside the sync window opens a frame in slot 0, and each later
// interval fills the next slot until the final slot is passed.
// A beat lands in the input register, and the interval, window compares
// and slot write happen as it moves on to the output register. One beat
// per cycle is sustained while the receiver keeps m_tready high; the input
// register and the output register each hold one beat.
// When the receiver stalls, the output register holds its beat and the
// input register still takes one more beat before s_tready drops.
// Reset clears the frame state and previous timestamp, loads the default
// thresholds and sets every slot to 1500. The APB port writes thresholds;
// writes should be made while no beat is in flight.
module ppm_sum_frame_decoder
	import ppmsfd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,

	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // [31:0] edge_time, [35:32] read_slot, [39:36] zero
	input  logic        s_tuser,   // [0] action

	output logic        m_tvalid,
	input  logic        m_tready,
	// [15:0] slot_value, [19:16] valid_count, [20] in_frame, [24:21] next_slot, [31:25] zero
	output logic [31:0] m_tdata,

	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	// Configuration registers.
	logic [15:0] sync_gap_min_q, sync_gap_max_q, pulse_min_q, pulse_max_q;
	logic [3:0]  final_slot_q;

	// Decoder state.
	logic [31:0] prev_edge_q;
	logic [3:0]  slot_ptr_q;
	logic        frame_active_q;
	logic [3:0]  good_pulses_q;
	logic [15:0] slot_store_q [NUM_SLOTS];

	// Input register.
	logic        valid_s1;
	action_t     action_s1;
	logic [31:0] edge_time_s1;
	logic [3:0]  read_slot_s1;

	// Output register.
	logic        out_valid_q;
	logic [31:0] out_data_q;

	logic        advance;
	logic        cfg_wr;
	cfg_reg_t    cfg_sel;

	logic [31:0] diff;
	logic        is_sync, in_pulse;
	logic [15:0] diff_sat;
	logic [3:0]  ptr_n, good_n;
	logic        active_n;
	logic        wr_en, last_written;
	logic [3:0]  wr_idx;
	logic [15:0] rd_value;

	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite & pready;
	assign cfg_sel = cfg_reg_t'(paddr[4:2]);

	always_comb begin
		unique case (cfg_sel)
			REG_SYNC_GAP_MIN: prdata = {16'd0, sync_gap_min_q};
			REG_SYNC_GAP_MAX: prdata = {16'd0, sync_gap_max_q};
			REG_PULSE_MIN:    prdata = {16'd0, pulse_min_q};
			REG_PULSE_MAX:    prdata = {16'd0, pulse_max_q};
			REG_FINAL_SLOT:   prdata = {28'd0, final_slot_q};
			default:          prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_gap_min_q <= SYNC_GAP_MIN_RST;
			sync_gap_max_q <= SYNC_GAP_MAX_RST;
			pulse_min_q    <= PULSE_MIN_RST;
			pulse_max_q    <= PULSE_MAX_RST;
			final_slot_q   <= FINAL_SLOT_RST;
		end else if (cfg_wr) begin
			unique case (cfg_sel)
				REG_SYNC_GAP_MIN: sync_gap_min_q <= pwdata[15:0];
				REG_SYNC_GAP_MAX: sync_gap_max_q <= pwdata[15:0];
				REG_PULSE_MIN:    pulse_min_q    <= pwdata[15:0];
				REG_PULSE_MAX:    pulse_max_q    <= pwdata[15:0];
				REG_FINAL_SLOT:   final_slot_q   <= pwdata[3:0];
				default: ;
			endcase
		end
	end

	// The input register moves on whenever the output register is free or
	// being drained this cycle.
	assign advance  = !out_valid_q || m_tready;
	assign s_tready = !valid_s1 || advance;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			action_s1    <= action_t'(s_tuser);
			edge_time_s1 <= s_tdata[31:0];
			read_slot_s1 <= s_tdata[35:32];
		end
	end

	assign diff     = edge_time_s1 - prev_edge_q;
	assign is_sync  = (diff > {16'd0, sync_gap_min_q}) && (diff < {16'd0, sync_gap_max_q});
	assign in_pulse = (diff >= {16'd0, pulse_min_q}) && (diff <= {16'd0, pulse_max_q});
	assign diff_sat = (|diff[31:16]) ? 16'hFFFF : diff[15:0];

	always_comb begin
		ptr_n        = slot_ptr_q;
		good_n       = good_pulses_q;
		active_n     = frame_active_q;
		wr_en        = 1'b0;
		wr_idx       = 4'd0;
		last_written = 1'b0;
		if (action_s1 == ACT_EDGE) begin
			if (is_sync) begin
				wr_en    = 1'b1;
				ptr_n    = 4'd1;
				good_n   = 4'd0;
				active_n = 1'b1;
			end else if (frame_active_q) begin
				wr_idx       = slot_ptr_q;
				wr_en        = {1'b0, slot_ptr_q} < 5'(NUM_SLOTS);
				last_written = ({1'b0, slot_ptr_q} + 5'd1) >= 5'(NUM_SLOTS);
				if (slot_ptr_q != PTR_MAX)
					ptr_n = slot_ptr_q + 4'd1;
				if (in_pulse && good_pulses_q != COUNT_MAX)
					good_n = good_pulses_q + 4'd1;
			end
			if (ptr_n > final_slot_q || last_written) begin
				active_n = 1'b0;
				good_n   = 4'd0;
			end
		end
	end

	always_comb begin
		rd_value = 16'd0;
		if (action_s1 == ACT_READ && {1'b0, read_slot_s1} < 5'(NUM_SLOTS))
			rd_value = slot_store_q[read_slot_s1[SLOT_IDX_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_edge_q    <= 32'd0;
			slot_ptr_q     <= 4'd0;
			frame_active_q <= 1'b0;
			good_pulses_q  <= 4'd0;
			for (int i = 0; i < NUM_SLOTS; i++)
				slot_store_q[i] <= SLOT_RST;
		end else if (advance && valid_s1 && action_s1 == ACT_EDGE) begin
			prev_edge_q    <= edge_time_s1;
			slot_ptr_q     <= ptr_n;
			frame_active_q <= active_n;
			good_pulses_q  <= good_n;
			if (wr_en)
				slot_store_q[wr_idx[SLOT_IDX_W-1:0]] <= diff_sat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1)
			out_data_q <= {7'd0, ptr_n, active_n, good_n, rd_value};
	end

`ifndef NO_ASSERTIONS
	// A frame in progress always points at a slot inside the store.
	a_frame_ptr: assert property (@(posedge clk) disable iff (!arst_n)
		frame_active_q |-> (slot_ptr_q != 4'd0 && {1'b0, slot_ptr_q} < 5'(NUM_SLOTS)))
		else $error("frame active with slot pointer out of range");

	// Outside a frame the pulse count is always clear.
	a_idle_count: assert property (@(posedge clk) disable iff (!arst_n)
		!frame_active_q |-> good_pulses_q == 4'd0)
		else $error("pulse count nonzero outside a frame");

	// An empty output register never backpressures the input side.
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled while output register empty");
`endif

endmodule
